[rtl/core/mlfs_pkg.sv]
package mlfs_pkg;

   localparam int NumTasks  = 64;
   localparam int NumLevels = 20;
   localparam int TickHz    = 100;
   localparam int QBase     = (TickHz / 20) * 4;
   localparam int QStep     = ((TickHz - QBase) / 40) * 2;

   localparam logic [20:0] FIXED_QUANTUM = 21'h0fffff;
   localparam logic [20:0] QUANTUM_MIN   = 21'h100000;
   localparam logic [7:0]  REBALANCE_RESET = 8'd10;

   localparam logic [1:0] CMD_SETPRI = 2'd0;
   localparam logic [1:0] CMD_READY  = 2'd1;
   localparam logic [1:0] CMD_TICK   = 2'd2;
   localparam logic [1:0] CMD_PICK   = 2'd3;

   localparam logic [1:0] ST_OK    = 2'd0;
   localparam logic [1:0] ST_EMPTY = 2'd1;
   localparam logic [1:0] ST_DUP   = 2'd2;

   // per-task record held in the task memory
   typedef struct packed {
      logic [4:0]  cur;
      logic [4:0]  base;
      logic        fixed;
      logic [20:0] quantum;
      logic [31:0] stamp;
      logic [5:0]  link;
      logic        queued;
   } task_rec_type;

   // time slice of a level
   function automatic logic [20:0] quantum_of(input logic [4:0] pri);
      logic [4:0] p;
      p = (pri >= 5'(NumLevels)) ? 5'(NumLevels - 1) : pri;
      return 21'(QBase + (NumLevels - 1 - int'(p)) * QStep);
   endfunction

endpackage

[rtl/core/multilevel_feedback_scheduler.sv]
// Multilevel feedback task scheduler.
// Requests enter on req_ (tdata: cmd[1:0], task_req[7:2], priority_req[12:8],
// fixed_priority[13]); one response per request leaves on rsp_ (tdata:
// status, picked_task, picked_priority, preempt, ready_mask, ready_total).
// Tasks live in one synchronous task memory (64 records); queue heads and
// tails live in a second memory (20 levels). Every access is a read, then
// a write back, run by a sequencer; one request is in work at a time.
// A pick that rebalances walks all 20 levels; the rebalance walk sets the
// worst case. The sequencer returns to idle after each request before the
// next one is accepted.
// Reset clears the per-task table by a sweep over all 64 records during
// which no request is taken; the period register resets to 10, is written
// at address 0 of the csr_ port and is read back at every csr_ address.
// A response waits in an output register while rsp_tready is low; the
// next request is accepted meanwhile and its own response holds in the
// final step until that register frees.
module multilevel_feedback_scheduler
   import mlfs_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   // cmd, task_req, priority_req, fixed_priority (low to high)
   input  logic [15:0] req_tdata,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   // status, picked_task, picked_priority, preempt, ready_mask, ready_total
   output logic [47:0] rsp_tdata,
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [1:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready
);

   localparam logic [4:0] S_CLEAR = 5'd0,  S_IDLE = 5'd1,  S_TRD = 5'd2,
      S_TOP = 5'd3,  S_TICK2 = 5'd4, S_EQ0 = 5'd5,  S_EQ1 = 5'd6,
      S_EQ2 = 5'd7,  S_EQ3 = 5'd8,  S_PK0 = 5'd9,  S_PK1 = 5'd10,
      S_PK2 = 5'd11, S_RB0 = 5'd12, S_RB1 = 5'd13, S_RB2 = 5'd14,
      S_RB3 = 5'd15, S_RB4 = 5'd16, S_DONE = 5'd17, S_DQ0 = 5'd18,
      S_DQ1 = 5'd19;

   // memories
   task_rec_type tmem [NumTasks];
   logic [11:0]  qmem [NumLevels];   // {head, tail}

   logic         t_we;
   logic [5:0]   t_addr, t_waddr;
   task_rec_type t_wdata, t_rdata;
   logic         q_we;
   logic [4:0]   q_addr, q_waddr;
   logic [11:0]  q_wdata, q_rdata;

   always_ff @(posedge clock) begin
      if (t_we) tmem[t_waddr] <= t_wdata;
      t_rdata <= tmem[t_addr];
      if (q_we) qmem[q_waddr] <= q_wdata;
      q_rdata <= qmem[q_addr];
   end

   // control state
   logic [4:0]  state_ff, state_in;
   logic [4:0]  ret_ff, ret_in;          // return after enqueue/dequeue
   logic [5:0]  cnt_ff, cnt_in;
   logic [1:0]  cmd_ff, cmd_in;
   logic [5:0]  tsk_ff, tsk_in;
   logic [4:0]  preq_ff, preq_in;
   logic        fix_ff, fix_in;
   logic        wasrun_ff, wasrun_in;
   logic [4:0]  lvl_ff, lvl_in;
   logic [4:0]  pri_ff, pri_in;
   task_rec_type rec_ff, rec_in;
   logic [19:0] bitmap_ff, bitmap_in;
   logic [6:0]  count_ff, count_in;
   logic [31:0] time_ff, time_in;
   logic [7:0]  pickc_ff, pickc_in;
   logic [5:0]  run_ff, run_in;
   logic        runv_ff, runv_in;
   logic [7:0]  period_ff, period_in;
   logic        outv_ff, outv_in;
   logic [40:0] out_ff, out_in;          // response held for rsp_
   logic [1:0]  ostat_ff, ostat_in;
   logic [5:0]  otask_ff, otask_in;
   logic [4:0]  opri_ff, opri_in;
   logic        opre_ff, opre_in;

   assign req_tready = (state_ff == S_IDLE);
   assign rsp_tvalid = outv_ff;
   assign rsp_tdata  = {7'd0, out_ff};
   assign csr_pready = 1'b1;
   assign csr_prdata = {24'd0, period_ff};

   // highest set level
   function automatic logic [4:0] top_level(input logic [19:0] bm);
      logic [4:0] r;
      r = 5'd0;
      for (int i = 0; i < NumLevels; i++)
         if (bm[i]) r = 5'(i);
      return r;
   endfunction

   logic [20:0] qcur;
   logic [20:0] qrec;
   logic [4:0]  above_sh;
   logic [19:0] above_mask;

   always_comb begin
      state_in = state_ff;  ret_in = ret_ff;   cnt_in = cnt_ff;
      cmd_in = cmd_ff;      tsk_in = tsk_ff;   preq_in = preq_ff;
      fix_in = fix_ff;      wasrun_in = wasrun_ff;
      lvl_in = lvl_ff;      pri_in = pri_ff;   rec_in = rec_ff;
      bitmap_in = bitmap_ff; count_in = count_ff; time_in = time_ff;
      pickc_in = pickc_ff;  run_in = run_ff;   runv_in = runv_ff;
      period_in = period_ff;
      outv_in = outv_ff;    out_in = out_ff;
      ostat_in = ostat_ff; otask_in = otask_ff;
      opri_in = opri_ff;    opre_in = opre_ff;
      t_we = 1'b0; t_waddr = tsk_ff; t_wdata = rec_ff; t_addr = tsk_ff;
      q_we = 1'b0; q_waddr = pri_ff; q_wdata = q_rdata; q_addr = pri_ff;
      qcur = quantum_of(t_rdata.cur);
      qrec = quantum_of(rec_ff.cur);
      above_sh = 5'd0;
      above_mask = 20'd0;

      if (outv_ff && rsp_tready) outv_in = 1'b0;
      if (csr_psel && csr_penable && csr_pwrite && csr_paddr == 2'd0)
         period_in = csr_pwdata[7:0];

      case (state_ff)
         S_CLEAR: begin
            t_we = 1'b1;
            t_waddr = cnt_ff;
            t_wdata = '0;
            cnt_in = cnt_ff + 6'd1;
            if (cnt_ff == 6'(NumTasks - 1)) state_in = S_IDLE;
         end
         S_IDLE: begin
            if (req_tvalid) begin
               cmd_in = req_tdata[1:0];
               tsk_in = req_tdata[7:2];
               preq_in = (req_tdata[12:8] >= 5'(NumLevels)) ?
                         5'(NumLevels - 1) : req_tdata[12:8];
               fix_in = req_tdata[13];
               ostat_in = ST_OK; otask_in = '0; opri_in = '0; opre_in = 1'b0;
               case (req_tdata[1:0])
                  CMD_TICK: begin
                     tsk_in = run_ff;
                     t_addr = run_ff;
                     time_in = time_ff + 32'd1;
                     state_in = S_TICK2;
                  end
                  CMD_PICK: begin
                     if (pickc_ff == period_ff) begin
                        pickc_in = 8'd0;
                        lvl_in = 5'd0;
                        state_in = S_RB0;
                     end else begin
                        pickc_in = pickc_ff + 8'd1;
                        state_in = S_PK0;
                     end
                  end
                  default: begin
                     t_addr = req_tdata[7:2];
                     state_in = S_TRD;
                  end
               endcase
            end
         end
         S_TRD: begin
            // set priority or ready, record available
            rec_in = t_rdata;
            if (cmd_ff == CMD_SETPRI) begin
               t_we = 1'b1;
               t_wdata = t_rdata;
               t_wdata.base = preq_ff;
               t_wdata.cur = preq_ff;
               t_wdata.fixed = fix_ff;
               t_wdata.quantum = fix_ff ? FIXED_QUANTUM : quantum_of(preq_ff);
               state_in = S_DONE;
            end else if (t_rdata.queued) begin
               ostat_in = ST_DUP;
               state_in = S_DONE;
            end else begin
               wasrun_in = runv_ff && (run_ff == tsk_ff);
               if (runv_ff && run_ff == tsk_ff) runv_in = 1'b0;
               ret_in = S_DONE;
               state_in = S_EQ0;
            end
         end
         S_TICK2: begin
            if (runv_ff) begin
               if ($signed(t_rdata.quantum) > $signed(QUANTUM_MIN)) begin
                  t_we = 1'b1;
                  t_wdata = t_rdata;
                  t_wdata.quantum = t_rdata.quantum - 21'd1;
               end
               above_sh = t_rdata.cur;
               above_mask = ~((20'd2 << above_sh) - 20'd1);
               if (t_rdata.cur == 5'd19) above_mask = 20'd0;
               opre_in = ((bitmap_ff & above_mask) != 0) ||
                         (!t_rdata.fixed && bitmap_ff != 0);
            end else begin
               opre_in = bitmap_ff != 0;
            end
            state_in = S_DONE;
         end
         // enqueue: rec_ff holds the task record, tsk_ff the task
         S_EQ0: begin
            pri_in = rec_ff.cur;
            if (rec_ff.fixed) begin
               pri_in = rec_ff.base;
               rec_in.quantum = 21'(TickHz);
            end else if (wasrun_ff) begin
               if ($signed(rec_ff.quantum) <= 0) begin
                  if (rec_ff.cur != 0) pri_in = rec_ff.cur - 5'd1;
                  rec_in.quantum = quantum_of((rec_ff.cur != 0) ?
                                              rec_ff.cur - 5'd1 : rec_ff.cur);
               end
            end else begin
               if ($signed(rec_ff.quantum) > $signed({1'b0, qrec[20:1]})) begin
                  pri_in = (rec_ff.cur + 5'd1 > rec_ff.base) ? rec_ff.base :
                           rec_ff.cur + 5'd1;
                  rec_in.quantum = quantum_of(pri_in);
               end else begin
                  rec_in.quantum = quantum_of(rec_ff.cur);
               end
            end
            if (pri_in >= 5'(NumLevels)) pri_in = 5'(NumLevels - 1);
            state_in = S_EQ1;
         end
         S_EQ1: begin
            q_addr = pri_ff;
            state_in = S_EQ2;
         end
         S_EQ2: begin
            // update tail, write record, read old tail to link it
            q_we = 1'b1;
            q_wdata = bitmap_ff[pri_ff] ? {q_rdata[11:6], tsk_ff} : {tsk_ff, tsk_ff};
            if (bitmap_ff[pri_ff]) begin
               t_addr = q_rdata[5:0];
               state_in = S_EQ3;
            end else begin
               state_in = ret_ff;
            end
            t_we = 1'b1;
            t_wdata = rec_ff;
            t_wdata.cur = pri_ff;
            t_wdata.queued = 1'b1;
            t_wdata.stamp = time_ff;
            bitmap_in = bitmap_ff | (20'd1 << pri_ff);
            count_in = count_ff + 7'd1;
            rec_in.link = q_rdata[5:0];   // old tail carried in link scratch
         end
         S_EQ3: begin
            t_we = 1'b1;
            t_waddr = rec_ff.link;
            t_wdata = t_rdata;
            t_wdata.link = tsk_ff;
            state_in = ret_ff;
         end
         // pick
         S_PK0: begin
            if (bitmap_ff == 0) begin
               ostat_in = ST_EMPTY;
               runv_in = 1'b0;
               state_in = S_DONE;
            end else begin
               pri_in = top_level(bitmap_ff);
               q_addr = top_level(bitmap_ff);
               ret_in = S_PK2;
               state_in = S_DQ0;
            end
         end
         // dequeue head of level pri_ff; q_rdata valid
         S_DQ0: begin
            t_addr = q_rdata[11:6];
            tsk_in = q_rdata[11:6];
            state_in = S_DQ1;
         end
         S_DQ1: begin
            rec_in = t_rdata;
            rec_in.queued = 1'b0;
            t_we = 1'b1;
            t_waddr = tsk_ff;
            t_wdata = t_rdata;
            t_wdata.queued = 1'b0;
            if (tsk_ff == q_rdata[5:0]) begin
               bitmap_in = bitmap_ff & ~(20'd1 << pri_ff);
            end else begin
               q_we = 1'b1;
               q_wdata = {t_rdata.link, q_rdata[5:0]};
            end
            count_in = count_ff - 7'd1;
            state_in = ret_ff;
         end
         S_PK2: begin
            otask_in = tsk_ff;
            opri_in = rec_ff.cur;
            run_in = tsk_ff;
            runv_in = 1'b1;
            state_in = S_DONE;
         end
         // rebalance walk over levels
         S_RB0: begin
            if (lvl_ff == 5'(NumLevels)) begin
               state_in = S_PK0;
            end else if (!bitmap_ff[lvl_ff]) begin
               lvl_in = lvl_ff + 5'd1;
            end else begin
               q_addr = lvl_ff;
               state_in = S_RB1;
            end
         end
         S_RB1: begin
            t_addr = q_rdata[11:6];
            state_in = S_RB2;
         end
         S_RB2: begin
            if (t_rdata.cur == t_rdata.base ||
                (time_ff - t_rdata.stamp) < {13'd0, qcur[20:2]}) begin
               lvl_in = lvl_ff + 5'd1;
               state_in = S_RB0;
            end else begin
               pri_in = lvl_ff;
               q_addr = lvl_ff;
               ret_in = S_RB3;
               state_in = S_DQ0;
            end
         end
         S_RB3: begin
            rec_in.quantum = quantum_of(rec_ff.cur);
            wasrun_in = 1'b0;
            ret_in = S_RB4;
            state_in = S_EQ0;
         end
         S_RB4: begin
            lvl_in = lvl_ff + 5'd1;
            state_in = S_RB0;
         end
         S_DONE: begin
            // hand over once the output register is free
            if (!outv_ff || rsp_tready) begin
               out_in = {count_ff, bitmap_ff, opre_ff, opri_ff, otask_ff, ostat_ff};
               outv_in = 1'b1;
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_CLEAR;
         cnt_ff <= '0;
         bitmap_ff <= '0;
         count_ff <= '0;
         time_ff <= '0;
         pickc_ff <= '0;
         run_ff <= '0;
         runv_ff <= 1'b0;
         period_ff <= REBALANCE_RESET;
         outv_ff <= 1'b0;
         ret_ff <= S_DONE;
      end else begin
         state_ff <= state_in;
         cnt_ff <= cnt_in;
         bitmap_ff <= bitmap_in;
         count_ff <= count_in;
         time_ff <= time_in;
         pickc_ff <= pickc_in;
         run_ff <= run_in;
         runv_ff <= runv_in;
         period_ff <= period_in;
         outv_ff <= outv_in;
         ret_ff <= ret_in;
      end
   end

   always_ff @(posedge clock) begin
      cmd_ff <= cmd_in;  tsk_ff <= tsk_in;  preq_ff <= preq_in;
      fix_ff <= fix_in;  wasrun_ff <= wasrun_in;
      lvl_ff <= lvl_in;  pri_ff <= pri_in;  rec_ff <= rec_in;
      ostat_ff <= ostat_in; otask_ff <= otask_in;
      opri_ff <= opri_in;   opre_ff <= opre_in;
      out_ff <= out_in;
   end

endmodule
